/* src/sorted_timer_queue_top_defines.svh */
// Assertion macros shared by the sorted timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_TIMER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted timer queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted timer queue: next-cycle check failed");

`endif

/* src/stq_pkg.sv */
// Types, codes and defaults for the sorted timer queue.
package stq_pkg;

    localparam int DEFAULT_DEPTH     = 16;
    localparam int DEFAULT_TIME_BITS = 32;
    localparam int MAX_RESULTS       = 16;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_DEL  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_REJECTED  = 3'd1;
    localparam logic [2:0] KIND_DELETED   = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_TICK_NONE = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  timer_id;
        logic [15:0] delay;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  timer_id_res;
        logic [31:0] expire_time;
        logic [31:0] next_delay;
        logic        armed;
        logic        last;
    } t_res_item;

endpackage

/* src/sorted_timer_queue_top.sv */
// Sorted one-shot timer queue: sequencer around a dual-port timer memory.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------
//  input   | in        | i_valid / o_ready  | i_item (mode, id, delay)
//  result  | out       | o_valid / i_ready  | o_res  (one timer event)
//
// An item scans or shifts the N queued timers and then waits on i_ready for its
// results: every entry visited by a scan or a shift passes a state that reads the
// timer memory (registered read) and a state that uses the data.
// A tick that expires P timers also passes S_EMIT_RD, S_EMIT_LD and S_OUT per result
// and S_CMP_RD, S_CMP_WR per entry moved when the survivors slide to the head.
// Synchronous reset clears occupancy and time; the memory is not cleared.
// o_ready is low from acceptance until the last result of that item is taken and,
// on a tick, until the survivors have moved to the head.
`include "sorted_timer_queue_top_defines.svh"

module sorted_timer_queue_top #(
    parameter int DEPTH     = stq_pkg::DEFAULT_DEPTH,
    parameter int TIME_BITS = stq_pkg::DEFAULT_TIME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  stq_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output stq_pkg::t_res_item o_res
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int SCAN_CAP = (DEPTH < stq_pkg::MAX_RESULTS) ? DEPTH : stq_pkg::MAX_RESULTS;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SCAN_RD  = 14'b00000000000010,
        S_SCAN_CHK = 14'b00000000000100,
        S_INS_RD   = 14'b00000000001000,
        S_INS_WR   = 14'b00000000010000,
        S_DEL_RD   = 14'b00000000100000,
        S_DEL_WR   = 14'b00000001000000,
        S_HEAD_RD  = 14'b00000010000000,
        S_HEAD_CHK = 14'b00000100000000,
        S_EMIT_RD  = 14'b00001000000000,
        S_EMIT_LD  = 14'b00010000000000,
        S_OUT      = 14'b00100000000000,
        S_CMP_RD   = 14'b01000000000000,
        S_CMP_WR   = 14'b10000000000000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_occ, n_occ;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [1:0]           r_mode, n_mode;
    logic [7:0]           r_id, n_id;
    logic [TIME_BITS-1:0] r_key, n_key;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic [CW-1:0]        r_pop, n_pop;
    logic [2:0]           r_kind, n_kind;
    logic [7:0]           r_rid, n_rid;
    logic [31:0]          r_rexp, n_rexp;
    logic [31:0]          r_nd, n_nd;
    logic                 r_armed, n_armed;
    logic                 r_last, n_last;

    logic [TIME_BITS-1:0] r_mem_exp [DEPTH];
    logic [7:0]           r_mem_id  [DEPTH];
    logic [TIME_BITS-1:0] r_rd_exp;
    logic [7:0]           r_rd_id;

    logic [CW-1:0]        rd_sel;
    logic                 wr_en;
    logic [CW-1:0]        wr_sel;
    logic [TIME_BITS-1:0] wr_exp;
    logic [7:0]           wr_id;

    logic                 is_tick;
    logic [TIME_BITS:0]   add_sum;
    logic [TIME_BITS-1:0] add_exp;
    logic [TIME_BITS-1:0] cmp_b;
    logic                 cmp_le;
    logic [TIME_BITS-1:0] diff;
    logic [CW-1:0]        occ_after;
    logic                 scan_cont;
    logic                 in_fire;

    assign is_tick  = (r_mode == stq_pkg::MODE_TICK);
    assign in_fire  = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);

    // Saturating expiry for an add
    assign add_sum = {1'b0, r_now} + (TIME_BITS + 1)'(i_item.delay);
    assign add_exp = add_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : add_sum[TIME_BITS-1:0];

    // Shared compare and subtract on the memory read data
    assign cmp_b  = (r_state == S_SCAN_CHK && r_mode == stq_pkg::MODE_ADD) ? r_key : r_now;
    assign cmp_le = (r_rd_exp <= cmp_b);
    assign diff   = r_rd_exp - r_now;

    assign occ_after = is_tick ? (r_occ - r_pop) : r_occ;

    always_comb begin
        case (r_mode)
            stq_pkg::MODE_DEL: scan_cont = (r_rd_id != r_id);
            default:           scan_cont = cmp_le;
        endcase
    end

    assign o_res.kind         = r_kind;
    assign o_res.timer_id_res = r_rid;
    assign o_res.expire_time  = r_rexp;
    assign o_res.next_delay   = r_nd;
    assign o_res.armed        = r_armed;
    assign o_res.last         = r_last;

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_now   = r_now;
        n_mode  = r_mode;
        n_id    = r_id;
        n_key   = r_key;
        n_idx   = r_idx;
        n_ptr   = r_ptr;
        n_pop   = r_pop;
        n_kind  = r_kind;
        n_rid   = r_rid;
        n_rexp  = r_rexp;
        n_nd    = r_nd;
        n_armed = r_armed;
        n_last  = r_last;
        rd_sel  = r_idx;
        wr_en   = 1'b0;
        wr_sel  = r_ptr;
        wr_exp  = r_rd_exp;
        wr_id   = r_rd_id;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_mode = i_item.mode;
                    n_id   = i_item.timer_id;
                    n_idx  = '0;
                    n_pop  = '0;
                    case (i_item.mode)
                        stq_pkg::MODE_ADD: begin
                            n_key = add_exp;
                            if (r_occ >= CW'(DEPTH)) begin
                                n_kind  = stq_pkg::KIND_REJECTED;
                                n_rid   = i_item.timer_id;
                                n_rexp  = 32'(add_exp);
                                n_last  = 1'b1;
                                n_state = S_HEAD_RD;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        stq_pkg::MODE_DEL: begin
                            n_state = S_SCAN_RD;
                        end
                        stq_pkg::MODE_TICK: begin
                            if (r_now != {TIME_BITS{1'b1}}) begin
                                n_now = r_now + 1'b1;
                            end
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            // unused mode: drop the transaction
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN_RD: begin
                rd_sel = r_idx;
                if (r_idx >= r_occ || (is_tick && r_idx >= CW'(SCAN_CAP))) begin
                    case (r_mode)
                        stq_pkg::MODE_ADD: begin
                            n_ptr   = r_occ;
                            n_state = S_INS_RD;
                        end
                        stq_pkg::MODE_DEL: begin
                            n_kind  = stq_pkg::KIND_NOT_FOUND;
                            n_rid   = r_id;
                            n_rexp  = '0;
                            n_last  = 1'b1;
                            n_state = S_HEAD_RD;
                        end
                        default: begin
                            n_pop   = r_idx;
                            n_kind  = stq_pkg::KIND_TICK_NONE;
                            n_rid   = '0;
                            n_rexp  = '0;
                            n_last  = 1'b1;
                            n_state = S_HEAD_RD;
                        end
                    endcase
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (scan_cont) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    case (r_mode)
                        stq_pkg::MODE_ADD: begin
                            n_ptr   = r_occ;
                            n_state = S_INS_RD;
                        end
                        stq_pkg::MODE_DEL: begin
                            n_key   = r_rd_exp;
                            n_ptr   = r_idx;
                            n_state = S_DEL_RD;
                        end
                        default: begin
                            n_pop   = r_idx;
                            n_kind  = stq_pkg::KIND_TICK_NONE;
                            n_rid   = '0;
                            n_rexp  = '0;
                            n_last  = 1'b1;
                            n_state = S_HEAD_RD;
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                rd_sel = r_ptr - 1'b1;
                if (r_ptr == r_idx) begin
                    wr_en   = 1'b1;
                    wr_sel  = r_idx;
                    wr_exp  = r_key;
                    wr_id   = r_id;
                    n_occ   = r_occ + 1'b1;
                    n_kind  = stq_pkg::KIND_ADDED;
                    n_rid   = r_id;
                    n_rexp  = 32'(r_key);
                    n_last  = 1'b1;
                    n_state = S_HEAD_RD;
                end else begin
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                // move one entry toward the tail
                wr_en   = 1'b1;
                wr_sel  = r_ptr;
                n_ptr   = r_ptr - 1'b1;
                n_state = S_INS_RD;
            end

            S_DEL_RD: begin
                rd_sel = r_ptr + 1'b1;
                if (r_ptr + 1'b1 >= r_occ) begin
                    n_occ   = r_occ - 1'b1;
                    n_kind  = stq_pkg::KIND_DELETED;
                    n_rid   = r_id;
                    n_rexp  = 32'(r_key);
                    n_last  = 1'b1;
                    n_state = S_HEAD_RD;
                end else begin
                    n_state = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                wr_en   = 1'b1;
                wr_sel  = r_ptr;
                n_ptr   = r_ptr + 1'b1;
                n_state = S_DEL_RD;
            end

            S_HEAD_RD: begin
                // new head sits past the expired run on a tick
                rd_sel = is_tick ? r_pop : '0;
                if (occ_after == '0) begin
                    n_nd    = '0;
                    n_armed = 1'b0;
                    if (is_tick && r_pop != '0) begin
                        n_idx   = '0;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_HEAD_CHK;
                end
            end

            S_HEAD_CHK: begin
                n_armed = 1'b1;
                n_nd    = cmp_le ? 32'd0 : 32'(diff);
                if (is_tick && r_pop != '0) begin
                    n_idx   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_OUT;
                end
            end

            S_EMIT_RD: begin
                rd_sel  = r_idx;
                n_state = S_EMIT_LD;
            end

            S_EMIT_LD: begin
                n_kind  = stq_pkg::KIND_EXPIRED;
                n_rid   = r_rd_id;
                n_rexp  = 32'(r_rd_exp);
                n_last  = (r_idx + 1'b1 == r_pop);
                n_state = S_OUT;
            end

            S_OUT: begin
                if (i_ready) begin
                    if (is_tick && r_pop != '0) begin
                        if (r_idx + 1'b1 < r_pop) begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_EMIT_RD;
                        end else begin
                            n_ptr   = '0;
                            n_state = S_CMP_RD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_CMP_RD: begin
                // slide the survivors to the head
                rd_sel = r_ptr + r_pop;
                if (r_ptr + r_pop >= r_occ) begin
                    n_occ   = r_occ - r_pop;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CMP_WR;
                end
            end

            S_CMP_WR: begin
                wr_en   = 1'b1;
                wr_sel  = r_ptr;
                n_ptr   = r_ptr + 1'b1;
                n_state = S_CMP_RD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_now   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_now   <= n_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_id    <= n_id;
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_ptr   <= n_ptr;
        r_pop   <= n_pop;
        r_kind  <= n_kind;
        r_rid   <= n_rid;
        r_rexp  <= n_rexp;
        r_nd    <= n_nd;
        r_armed <= n_armed;
        r_last  <= n_last;
    end

    // Timer memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_exp[wr_sel[AW-1:0]] <= wr_exp;
            r_mem_id[wr_sel[AW-1:0]]  <= wr_id;
        end
        r_rd_exp <= r_mem_exp[rd_sel[AW-1:0]];
        r_rd_id  <= r_mem_id[rd_sel[AW-1:0]];
    end

    `STQ_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CW'(DEPTH))
    `STQ_ASSERT_NOW(a_idle_no_result, i_clk, i_rst_n, o_valid, !o_ready)
    `STQ_ASSERT_NOW(a_disarmed_zero, i_clk, i_rst_n, o_valid && !o_res.armed, o_res.next_delay == 32'd0)
    `STQ_ASSERT_NOW(a_emit_in_run, i_clk, i_rst_n, r_state == S_EMIT_RD, r_idx < r_pop)
    `STQ_ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_valid && i_ready && o_res.last && !is_tick, o_ready)

endmodule
